// ===== design/mips_instruction_word_encoder_top_defines.svh =====
// assertion macros shared by the encoder's checker
// no dependencies; clock and reset names follow the top level ports
`ifndef MIPS_INSTRUCTION_WORD_ENCODER_TOP_DEFINES_SVH
`define MIPS_INSTRUCTION_WORD_ENCODER_TOP_DEFINES_SVH

// property checked at every clock edge outside reset
`define MIPSENC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property checked at every clock edge, reset included
`define MIPSENC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/mipsenc_pkg.sv =====
// types, opcode constants and the mnemonic decode table of the instruction encoder
// no dependencies
package mipsenc_pkg;

  localparam int unsigned InTdataW  = 64;
  localparam int unsigned OutTdataW = 32;

  // mnemonic codes in alphabetical order
  typedef enum logic [5:0] {
    MN_ADD, MN_ADDI, MN_ADDIU, MN_ADDU, MN_AND, MN_ANDI, MN_BEQ, MN_BGEZ,
    MN_BGEZAL, MN_BGTZ, MN_BLEZ, MN_BLTZ, MN_BLTZAL, MN_BNE, MN_DIV, MN_DIVU,
    MN_J, MN_JAL, MN_JR, MN_LB, MN_LUI, MN_LW, MN_MFHI, MN_MFLO,
    MN_MULT, MN_MULTU, MN_NOOP, MN_OR, MN_ORI, MN_SB, MN_SLL, MN_SLLV,
    MN_SLT, MN_SLTI, MN_SLTIU, MN_SLTU, MN_SRA, MN_SRL, MN_SRLV, MN_SUB,
    MN_SUBU, MN_SW, MN_SYSCALL, MN_XOR, MN_XORI
  } mnem_e;

  // operand placement forms
  typedef enum logic [3:0] {
    KIND_R3, KIND_I, KIND_SHIFT, KIND_R2, KIND_MEM, KIND_JUMP,
    KIND_BRSUB, KIND_LUI, KIND_JR, KIND_MF, KIND_FIXED, KIND_INVALID
  } kind_e;

  // r-type function codes
  localparam logic [5:0] FN_SLL   = 6'h00;
  localparam logic [5:0] FN_SRL   = 6'h02;
  localparam logic [5:0] FN_SRA   = 6'h03;
  localparam logic [5:0] FN_SLLV  = 6'h04;
  localparam logic [5:0] FN_SRLV  = 6'h06;
  localparam logic [5:0] FN_JR    = 6'h08;
  localparam logic [5:0] FN_MFHI  = 6'h10;
  localparam logic [5:0] FN_MFLO  = 6'h12;
  localparam logic [5:0] FN_MULT  = 6'h18;
  localparam logic [5:0] FN_MULTU = 6'h19;
  localparam logic [5:0] FN_DIV   = 6'h1A;
  localparam logic [5:0] FN_DIVU  = 6'h1B;
  localparam logic [5:0] FN_ADD   = 6'h20;
  localparam logic [5:0] FN_ADDU  = 6'h21;
  localparam logic [5:0] FN_SUB   = 6'h22;
  localparam logic [5:0] FN_SUBU  = 6'h23;
  localparam logic [5:0] FN_AND   = 6'h24;
  localparam logic [5:0] FN_OR    = 6'h25;
  localparam logic [5:0] FN_XOR   = 6'h26;
  localparam logic [5:0] FN_SLT   = 6'h2A;
  localparam logic [5:0] FN_SLTU  = 6'h2B;

  // primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0A;
  localparam logic [5:0] OP_SLTIU   = 6'h0B;
  localparam logic [5:0] OP_ANDI    = 6'h0C;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_XORI    = 6'h0E;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SW      = 6'h2B;

  // regimm rt subcodes
  localparam logic [4:0] RT_BLTZ   = 5'h00;
  localparam logic [4:0] RT_BGEZ   = 5'h01;
  localparam logic [4:0] RT_BLTZAL = 5'h10;
  localparam logic [4:0] RT_BGEZAL = 5'h11;
  localparam logic [4:0] RT_NONE   = 5'h00;

  // word given for noop and syscall
  localparam logic [5:0] WORD_FIXED = 6'h0C;

  typedef struct packed {
    logic [25:0] target_index;
    logic [15:0] immediate;
    logic [4:0]  third_reg;
    logic [4:0]  second_reg;
    logic [4:0]  first_reg;
    logic [5:0]  func;
  } in_item_t;

  typedef struct packed {
    kind_e      kind;
    logic [5:0] code;
    logic [4:0] sub;
  } enc_entry_t;

  function automatic enc_entry_t enc_lookup(logic [5:0] func);
    enc_entry_t e;
    e = '{kind: KIND_INVALID, code: OP_SPECIAL, sub: RT_NONE};
    case (func)
      MN_ADD:     e = '{KIND_R3,    FN_ADD,     RT_NONE};
      MN_ADDI:    e = '{KIND_I,     OP_ADDI,    RT_NONE};
      MN_ADDIU:   e = '{KIND_I,     OP_ADDIU,   RT_NONE};
      MN_ADDU:    e = '{KIND_R3,    FN_ADDU,    RT_NONE};
      MN_AND:     e = '{KIND_R3,    FN_AND,     RT_NONE};
      MN_ANDI:    e = '{KIND_I,     OP_ANDI,    RT_NONE};
      MN_BEQ:     e = '{KIND_I,     OP_BEQ,     RT_NONE};
      MN_BGEZ:    e = '{KIND_BRSUB, OP_REGIMM,  RT_BGEZ};
      MN_BGEZAL:  e = '{KIND_BRSUB, OP_REGIMM,  RT_BGEZAL};
      MN_BGTZ:    e = '{KIND_BRSUB, OP_BGTZ,    RT_NONE};
      MN_BLEZ:    e = '{KIND_BRSUB, OP_BLEZ,    RT_NONE};
      MN_BLTZ:    e = '{KIND_BRSUB, OP_REGIMM,  RT_BLTZ};
      MN_BLTZAL:  e = '{KIND_BRSUB, OP_REGIMM,  RT_BLTZAL};
      MN_BNE:     e = '{KIND_I,     OP_BNE,     RT_NONE};
      MN_DIV:     e = '{KIND_R2,    FN_DIV,     RT_NONE};
      MN_DIVU:    e = '{KIND_R2,    FN_DIVU,    RT_NONE};
      MN_J:       e = '{KIND_JUMP,  OP_J,       RT_NONE};
      MN_JAL:     e = '{KIND_JUMP,  OP_JAL,     RT_NONE};
      MN_JR:      e = '{KIND_JR,    FN_JR,      RT_NONE};
      MN_LB:      e = '{KIND_MEM,   OP_LB,      RT_NONE};
      MN_LUI:     e = '{KIND_LUI,   OP_LUI,     RT_NONE};
      MN_LW:      e = '{KIND_MEM,   OP_LW,      RT_NONE};
      MN_MFHI:    e = '{KIND_MF,    FN_MFHI,    RT_NONE};
      MN_MFLO:    e = '{KIND_MF,    FN_MFLO,    RT_NONE};
      MN_MULT:    e = '{KIND_R2,    FN_MULT,    RT_NONE};
      MN_MULTU:   e = '{KIND_R2,    FN_MULTU,   RT_NONE};
      MN_NOOP:    e = '{KIND_FIXED, WORD_FIXED, RT_NONE};
      MN_OR:      e = '{KIND_R3,    FN_OR,      RT_NONE};
      MN_ORI:     e = '{KIND_I,     OP_ORI,     RT_NONE};
      MN_SB:      e = '{KIND_MEM,   OP_SB,      RT_NONE};
      MN_SLL:     e = '{KIND_SHIFT, FN_SLL,     RT_NONE};
      MN_SLLV:    e = '{KIND_R3,    FN_SLLV,    RT_NONE};
      MN_SLT:     e = '{KIND_R3,    FN_SLT,     RT_NONE};
      MN_SLTI:    e = '{KIND_I,     OP_SLTI,    RT_NONE};
      MN_SLTIU:   e = '{KIND_I,     OP_SLTIU,   RT_NONE};
      MN_SLTU:    e = '{KIND_R3,    FN_SLTU,    RT_NONE};
      MN_SRA:     e = '{KIND_SHIFT, FN_SRA,     RT_NONE};
      MN_SRL:     e = '{KIND_SHIFT, FN_SRL,     RT_NONE};
      MN_SRLV:    e = '{KIND_R3,    FN_SRLV,    RT_NONE};
      MN_SUB:     e = '{KIND_R3,    FN_SUB,     RT_NONE};
      MN_SUBU:    e = '{KIND_R3,    FN_SUBU,    RT_NONE};
      MN_SW:      e = '{KIND_MEM,   OP_SW,      RT_NONE};
      MN_SYSCALL: e = '{KIND_FIXED, WORD_FIXED, RT_NONE};
      MN_XOR:     e = '{KIND_R3,    FN_XOR,     RT_NONE};
      MN_XORI:    e = '{KIND_I,     OP_XORI,    RT_NONE};
      default:    e = '{KIND_INVALID, OP_SPECIAL, RT_NONE};
    endcase
    return e;
  endfunction

endpackage

// ===== design/mipsenc_in_reg.sv =====
// input register stage of the instruction encoder: holds one tokenized item
// depends on mipsenc_pkg
module mipsenc_in_reg
  import mipsenc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     ready_o,
  input  in_item_t item_i,
  output logic     valid_o,
  input  logic     ready_i,
  output in_item_t item_o
);

  logic     valid_q;
  in_item_t item_q;

  // the stage refills whenever its item leaves in the same cycle
  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

endmodule

// ===== design/mipsenc_encode.sv =====
// combinational encoder: decodes the mnemonic and packs the 32-bit word
// depends on mipsenc_pkg
module mipsenc_encode
  import mipsenc_pkg::*;
(
  input  in_item_t    item_i,
  output logic [31:0] word_o,
  output logic        invalid_o
);

  enc_entry_t e;
  logic [4:0] a, b, c;

  assign e = enc_lookup(item_i.func);
  assign a = item_i.first_reg;
  assign b = item_i.second_reg;
  assign c = item_i.third_reg;

  always_comb begin
    invalid_o = 1'b0;
    case (e.kind)
      KIND_R3:    word_o = {OP_SPECIAL, b, c, a, 5'd0, e.code};
      KIND_I:     word_o = {e.code, a, b, item_i.immediate};
      KIND_SHIFT: word_o = {OP_SPECIAL, a, b, 5'd0, item_i.immediate[4:0], e.code};
      KIND_R2:    word_o = {OP_SPECIAL, a, b, 10'd0, e.code};
      KIND_MEM:   word_o = {e.code, b, a, item_i.immediate};
      KIND_JUMP:  word_o = {e.code, item_i.target_index};
      KIND_BRSUB: word_o = {e.code, a, e.sub, item_i.immediate};
      KIND_LUI:   word_o = {e.code, 5'd0, a, item_i.immediate};
      KIND_JR:    word_o = {OP_SPECIAL, a, 15'd0, e.code};
      KIND_MF:    word_o = {16'd0, a, 5'd0, e.code};
      KIND_FIXED: word_o = {26'd0, e.code};
      default: begin
        // codes past the mnemonic list
        word_o    = '0;
        invalid_o = 1'b1;
      end
    endcase
  end

endmodule

// ===== design/mipsenc_out_reg.sv =====
// result register stage of the instruction encoder: holds one encoded word
// no package dependencies
module mipsenc_out_reg (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [31:0] word_i,
  input  logic        invalid_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [31:0] word_o,
  output logic        invalid_o
);

  logic        valid_q;
  logic [31:0] word_q;
  logic        invalid_q;

  assign ready_o   = !valid_q || ready_i;
  assign valid_o   = valid_q;
  assign word_o    = word_q;
  assign invalid_o = invalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      word_q    <= word_i;
      invalid_q <= invalid_i;
    end
  end

endmodule

// ===== design/mips_instruction_word_encoder_top.sv =====
// MIPS32 instruction word encoder, top level
// depends on mipsenc_pkg, mipsenc_in_reg, mipsenc_encode, mipsenc_out_reg
//
// Takes one tokenized instruction per item on the s_axis channel and gives
// its 32-bit machine word on the m_axis channel, one result per item, in order.
// Input tdata carries func, first_reg, second_reg, third_reg, immediate and
// target_index; output tdata carries the word and tuser flags an unknown
// mnemonic code (the word is then zero).
// m_axis_tvalid rises once the accepted item has passed both registers: the
// input register takes it at the accepting edge, the decode and packing logic
// feeds the result register, which loads it when it is free.
// Throughput is one item per cycle while the receiver keeps m_axis_tready high;
// the decode table lookup and field packing sit between the two registers.
// Reset clears both stage valid bits; nothing is held across reset.
// When the receiver stalls the result register holds its item and the input
// register still takes one more item; s_axis_tready falls only once both
// stages are full.
module mips_instruction_word_encoder_top
  import mipsenc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // func[5:0], first_reg[10:6], second_reg[15:11], third_reg[20:16],
  // immediate[36:21], target_index[62:37], zero pad [63]
  input  logic [InTdataW-1:0]  s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // instruction_word[31:0]
  output logic [OutTdataW-1:0] m_axis_tdata,
  // invalid[0]
  output logic                 m_axis_tuser
);

  in_item_t    in_item, stage_item;
  logic        stage_valid, stage_ready;
  logic [31:0] enc_word;
  logic        enc_invalid;

  assign in_item = s_axis_tdata[$bits(in_item_t)-1:0];

  mipsenc_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (in_item),
    .valid_o (stage_valid),
    .ready_i (stage_ready),
    .item_o  (stage_item)
  );

  mipsenc_encode u_encode (
    .item_i    (stage_item),
    .word_o    (enc_word),
    .invalid_o (enc_invalid)
  );

  mipsenc_out_reg u_out_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (stage_valid),
    .ready_o   (stage_ready),
    .word_i    (enc_word),
    .invalid_i (enc_invalid),
    .valid_o   (m_axis_tvalid),
    .ready_i   (m_axis_tready),
    .word_o    (m_axis_tdata),
    .invalid_o (m_axis_tuser)
  );

endmodule

// ===== design/mipsenc_checker.sv =====
// port-level checker for the instruction encoder, bound to the top level
// depends on mipsenc_pkg and mips_instruction_word_encoder_top_defines.svh
`include "mips_instruction_word_encoder_top_defines.svh"

module mipsenc_checker
  import mipsenc_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [OutTdataW-1:0] m_axis_tdata,
  input logic                 m_axis_tuser
);

  // a stalled result keeps its word and flag
  `MIPSENC_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

  // an unknown mnemonic always gives a zero word
  `MIPSENC_ASSERT(a_invalid_zero, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0, "invalid item with nonzero word")

  // an accepted item passes both registers to the output when the receiver keeps up
  `MIPSENC_ASSERT(a_latency, s_axis_tvalid && s_axis_tready ##1 m_axis_tready |=> m_axis_tvalid, "item lost in the pipeline")

  // no result is offered while reset is held
  `MIPSENC_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !m_axis_tvalid, "result valid during reset")

endmodule

bind mips_instruction_word_encoder_top mipsenc_checker u_mipsenc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/tb_mips_instruction_word_encoder_top.sv =====
// testbench for mips_instruction_word_encoder_top: directed table, then random instructions
// depends on mipsenc_pkg and encoder rtl; untyped rows are checked against a local encoder model
`timescale 1ns / 1ps

module tb_mips_instruction_word_encoder_top;
  import mipsenc_pkg::*;

  localparam int RandomItems = 2000;
  localparam int DirectedRows = 27;
  localparam int CycleLimit = 200000;
  localparam int DrainCycles = 10;
  localparam int IdlePercent = 24;
  localparam logic [5:0] FirstUnknownCode = 6'd45;
  localparam logic [5:0] TopCode = 6'h3F;

  typedef struct packed {
    logic [31:0] word;
    logic        invalid;
  } enc_result_t;

  // one instruction to send, with a typed-in word where it is obvious
  typedef struct packed {
    in_item_t    instr;
    logic        typed;
    logic [31:0] word;
    logic        inv;
  } stim_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic                 m_axis_tuser;

  stim_row_t   instr_fifo[$];
  enc_result_t words_due[$];
  stim_row_t   directed_rows[DirectedRows];
  stim_row_t   cur_row;
  int          items_sent = 0;
  int          results_seen = 0;
  int          invalid_seen = 0;
  int          error_count = 0;
  int          cycle_count = 0;

  mips_instruction_word_encoder_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [31:0] pack_register_form(logic [4:0] rs, logic [4:0] rt,
                                                     logic [4:0] rd, logic [4:0] sh,
                                                     logic [5:0] fn);
    return {OP_SPECIAL, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] pack_immediate_form(logic [5:0] op, logic [4:0] rs,
                                                      logic [4:0] rt, logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic enc_result_t encode_instruction(in_item_t it);
    enc_result_t r;
    logic [4:0]  a;
    logic [4:0]  b;
    logic [4:0]  c;
    logic [15:0] imm;
    r = '0;
    a = it.first_reg;
    b = it.second_reg;
    c = it.third_reg;
    imm = it.immediate;
    case (it.func)
      MN_ADD:     r.word = pack_register_form(b, c, a, 5'd0, FN_ADD);
      MN_ADDU:    r.word = pack_register_form(b, c, a, 5'd0, FN_ADDU);
      MN_AND:     r.word = pack_register_form(b, c, a, 5'd0, FN_AND);
      MN_OR:      r.word = pack_register_form(b, c, a, 5'd0, FN_OR);
      MN_SLLV:    r.word = pack_register_form(b, c, a, 5'd0, FN_SLLV);
      MN_SLT:     r.word = pack_register_form(b, c, a, 5'd0, FN_SLT);
      MN_SLTU:    r.word = pack_register_form(b, c, a, 5'd0, FN_SLTU);
      MN_SRLV:    r.word = pack_register_form(b, c, a, 5'd0, FN_SRLV);
      MN_SUB:     r.word = pack_register_form(b, c, a, 5'd0, FN_SUB);
      MN_SUBU:    r.word = pack_register_form(b, c, a, 5'd0, FN_SUBU);
      MN_XOR:     r.word = pack_register_form(b, c, a, 5'd0, FN_XOR);
      MN_ADDI:    r.word = pack_immediate_form(OP_ADDI, a, b, imm);
      MN_ADDIU:   r.word = pack_immediate_form(OP_ADDIU, a, b, imm);
      MN_ANDI:    r.word = pack_immediate_form(OP_ANDI, a, b, imm);
      MN_BEQ:     r.word = pack_immediate_form(OP_BEQ, a, b, imm);
      MN_BNE:     r.word = pack_immediate_form(OP_BNE, a, b, imm);
      MN_ORI:     r.word = pack_immediate_form(OP_ORI, a, b, imm);
      MN_SLTI:    r.word = pack_immediate_form(OP_SLTI, a, b, imm);
      MN_SLTIU:   r.word = pack_immediate_form(OP_SLTIU, a, b, imm);
      MN_XORI:    r.word = pack_immediate_form(OP_XORI, a, b, imm);
      // shift amount is the low five bits of the immediate
      MN_SLL:     r.word = pack_register_form(a, b, 5'd0, imm[4:0], FN_SLL);
      MN_SRA:     r.word = pack_register_form(a, b, 5'd0, imm[4:0], FN_SRA);
      MN_SRL:     r.word = pack_register_form(a, b, 5'd0, imm[4:0], FN_SRL);
      MN_DIV:     r.word = pack_register_form(a, b, 5'd0, 5'd0, FN_DIV);
      MN_DIVU:    r.word = pack_register_form(a, b, 5'd0, 5'd0, FN_DIVU);
      MN_MULT:    r.word = pack_register_form(a, b, 5'd0, 5'd0, FN_MULT);
      MN_MULTU:   r.word = pack_register_form(a, b, 5'd0, 5'd0, FN_MULTU);
      // loads and stores: base register goes to rs
      MN_LB:      r.word = pack_immediate_form(OP_LB, b, a, imm);
      MN_LW:      r.word = pack_immediate_form(OP_LW, b, a, imm);
      MN_SB:      r.word = pack_immediate_form(OP_SB, b, a, imm);
      MN_SW:      r.word = pack_immediate_form(OP_SW, b, a, imm);
      MN_J:       r.word = {OP_J, it.target_index};
      MN_JAL:     r.word = {OP_JAL, it.target_index};
      MN_BGEZ:    r.word = pack_immediate_form(OP_REGIMM, a, RT_BGEZ, imm);
      MN_BGEZAL:  r.word = pack_immediate_form(OP_REGIMM, a, RT_BGEZAL, imm);
      MN_BLTZ:    r.word = pack_immediate_form(OP_REGIMM, a, RT_BLTZ, imm);
      MN_BLTZAL:  r.word = pack_immediate_form(OP_REGIMM, a, RT_BLTZAL, imm);
      MN_BGTZ:    r.word = pack_immediate_form(OP_BGTZ, a, RT_NONE, imm);
      MN_BLEZ:    r.word = pack_immediate_form(OP_BLEZ, a, RT_NONE, imm);
      MN_LUI:     r.word = pack_immediate_form(OP_LUI, 5'd0, a, imm);
      MN_JR:      r.word = pack_register_form(a, 5'd0, 5'd0, 5'd0, FN_JR);
      MN_MFHI:    r.word = pack_register_form(5'd0, 5'd0, a, 5'd0, FN_MFHI);
      MN_MFLO:    r.word = pack_register_form(5'd0, 5'd0, a, 5'd0, FN_MFLO);
      MN_NOOP:    r.word = {26'd0, WORD_FIXED};
      MN_SYSCALL: r.word = {26'd0, WORD_FIXED};
      default:    r.invalid = 1'b1;
    endcase
    return r;
  endfunction

  function automatic stim_row_t row(logic [5:0] f, logic [4:0] a, logic [4:0] b,
                                    logic [4:0] c, logic [15:0] imm, logic [25:0] tgt,
                                    logic typed, logic [31:0] word, logic inv);
    stim_row_t s;
    s.instr = '{target_index: tgt, immediate: imm, third_reg: c, second_reg: b,
                first_reg: a, func: f};
    s.typed = typed;
    s.word = word;
    s.inv = inv;
    return s;
  endfunction

  function automatic stim_row_t random_row();
    logic [5:0]  f;
    logic [15:0] imm;
    // mostly known mnemonics, some unknown codes
    if ($urandom_range(99) < 12) f = 6'($urandom_range(TopCode, FirstUnknownCode));
    else f = 6'($urandom_range(MN_XORI, MN_ADD));
    case ($urandom_range(9))
      0: imm = 16'h0000;
      1: imm = 16'hFFFF;
      default: imm = 16'($urandom);
    endcase
    return row(f, 5'($urandom_range(31)), 5'($urandom_range(31)), 5'($urandom_range(31)),
               imm, 26'($urandom), 1'b0, 32'd0, 1'b0);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on result %0d: %s got %h want %h", results_seen, what, got, want);
    error_count++;
  endtask

  // drive instructions, take results and compare in one place
  always @(posedge clk_i) begin
    enc_result_t want;
    stim_row_t   nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (cur_row.typed) want = '{word: cur_row.word, invalid: cur_row.inv};
        else want = encode_instruction(cur_row.instr);
        words_due.push_back(want);
        items_sent++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (words_due.size() == 0) begin
          report_mismatch("result with nothing expected", m_axis_tdata, 32'd0);
        end else begin
          want = words_due.pop_front();
          if (m_axis_tdata !== want.word) report_mismatch("word", m_axis_tdata, want.word);
          if (m_axis_tuser !== want.invalid)
            report_mismatch("invalid flag", {31'd0, m_axis_tuser}, {31'd0, want.invalid});
          if (want.invalid) invalid_seen++;
        end
        results_seen++;
      end
      // a held item stays up until taken; idling is off for a stretch mid run
      if (!s_axis_tvalid || s_axis_tready) begin
        if (instr_fifo.size() != 0 && ((items_sent >= 800 && items_sent < 1100) ||
                                       $urandom_range(99) >= IdlePercent)) begin
          nxt = instr_fifo.pop_front();
          cur_row = nxt;
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {1'b0, nxt.instr};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= (results_seen >= 800 && results_seen < 1100) ||
                       ($urandom_range(99) >= IdlePercent);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count, words_due.size());
      $display("tb_mips_instruction_word_encoder_top failed");
      $finish;
    end
  end

  initial begin
    // a real falling edge on reset so the design clears at time zero
    rst_ni <= 1'b0;
    directed_rows[0]  = row(MN_ADD, 5'd0, 5'd0, 5'd0, 16'h0000, 26'd0, 1'b1, 32'h00000020,
                            1'b0);
    directed_rows[1]  = row(MN_ADD, 5'd31, 5'd31, 5'd31, 16'hFFFF, '1, 1'b0, 32'd0, 1'b0);
    directed_rows[2]  = row(MN_ADDI, 5'd31, 5'd31, 5'd31, 16'hFFFF, '1, 1'b1, 32'h23FFFFFF,
                            1'b0);
    directed_rows[3]  = row(MN_ANDI, 5'd1, 5'd2, 5'd3, 16'h8000, 26'd0, 1'b0, 32'd0, 1'b0);
    directed_rows[4]  = row(MN_BEQ, 5'd31, 5'd0, 5'd17, 16'h0000, 26'd5, 1'b0, 32'd0, 1'b0);
    // register b is not used by the subcode branches
    directed_rows[5]  = row(MN_BGEZ, 5'd5, 5'd31, 5'd0, 16'h1234, 26'd0, 1'b0, 32'd0, 1'b0);
    directed_rows[6]  = row(MN_BGEZAL, 5'd31, 5'd31, 5'd31, 16'hFFFF, '1, 1'b0, 32'd0, 1'b0);
    directed_rows[7]  = row(MN_BGTZ, 5'd7, 5'd31, 5'd31, 16'h0001, 26'd0, 1'b0, 32'd0, 1'b0);
    directed_rows[8]  = row(MN_BLEZ, 5'd0, 5'd31, 5'd31, 16'hFFFE, 26'd0, 1'b0, 32'd0, 1'b0);
    directed_rows[9]  = row(MN_BLTZ, 5'd31, 5'd31, 5'd31, 16'h7FFF, '1, 1'b0, 32'd0, 1'b0);
    directed_rows[10] = row(MN_BLTZAL, 5'd16, 5'd8, 5'd4, 16'hAAAA, 26'd0, 1'b0, 32'd0, 1'b0);
    directed_rows[11] = row(MN_DIV, 5'd31, 5'd31, 5'd31, 16'hFFFF, '1, 1'b0, 32'd0, 1'b0);
    directed_rows[12] = row(MN_J, 5'd31, 5'd31, 5'd31, 16'hFFFF, '1, 1'b1, 32'h0BFFFFFF,
                            1'b0);
    directed_rows[13] = row(MN_JAL, 5'd0, 5'd0, 5'd0, 16'h0000, 26'd0, 1'b1, 32'h0C000000,
                            1'b0);
    directed_rows[14] = row(MN_JR, 5'd31, 5'd31, 5'd31, 16'hFFFF, '1, 1'b0, 32'd0, 1'b0);
    directed_rows[15] = row(MN_LB, 5'd3, 5'd29, 5'd0, 16'hFFFC, 26'd0, 1'b0, 32'd0, 1'b0);
    directed_rows[16] = row(MN_LUI, 5'd31, 5'd31, 5'd31, 16'hFFFF, '1, 1'b0, 32'd0, 1'b0);
    directed_rows[17] = row(MN_MFHI, 5'd31, 5'd31, 5'd31, 16'hFFFF, '1, 1'b0, 32'd0, 1'b0);
    directed_rows[18] = row(MN_MFLO, 5'd1, 5'd0, 5'd0, 16'h0000, 26'd0, 1'b0, 32'd0, 1'b0);
    directed_rows[19] = row(MN_NOOP, 5'd31, 5'd31, 5'd31, 16'hFFFF, '1, 1'b1, 32'h0000000C,
                            1'b0);
    directed_rows[20] = row(MN_SYSCALL, 5'd31, 5'd31, 5'd31, 16'hFFFF, '1, 1'b1,
                            32'h0000000C, 1'b0);
    // shift amount above 31 is cut to five bits
    directed_rows[21] = row(MN_SLL, 5'd31, 5'd31, 5'd31, 16'hFFFF, '1, 1'b0, 32'd0, 1'b0);
    directed_rows[22] = row(MN_SRA, 5'd2, 5'd9, 5'd0, 16'h0020, 26'd0, 1'b0, 32'd0, 1'b0);
    directed_rows[23] = row(MN_XORI, 5'd31, 5'd31, 5'd31, 16'hFFFF, '1, 1'b0, 32'd0, 1'b0);
    directed_rows[24] = row(MN_SW, 5'd31, 5'd0, 5'd31, 16'h7FFF, 26'd0, 1'b0, 32'd0, 1'b0);
    directed_rows[25] = row(FirstUnknownCode, 5'd31, 5'd31, 5'd31, 16'hFFFF, '1, 1'b1,
                            32'd0, 1'b1);
    directed_rows[26] = row(TopCode, 5'd0, 5'd0, 5'd0, 16'h0000, 26'd0, 1'b1, 32'd0, 1'b1);
    for (int i = 0; i < DirectedRows; i++) instr_fifo.push_back(directed_rows[i]);
    for (int i = 0; i < RandomItems; i++) instr_fifo.push_back(random_row());

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (instr_fifo.size() != 0 || s_axis_tvalid || words_due.size() != 0)
      @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    $display("sent %0d instructions (%0d directed), checked %0d words, %0d unknown codes",
             items_sent, DirectedRows, results_seen, invalid_seen);
    if (error_count == 0) begin
      $display("tb_mips_instruction_word_encoder_top passed");
    end else begin
      $display("%0d mismatches", error_count);
      $display("tb_mips_instruction_word_encoder_top failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/mipsenc_pkg.sv
design/mipsenc_in_reg.sv
design/mipsenc_encode.sv
design/mipsenc_out_reg.sv
design/mips_instruction_word_encoder_top.sv
design/mipsenc_checker.sv
tb/tb_mips_instruction_word_encoder_top.sv
